// ===== design/pstq_pkg.sv =====
package pstq_pkg;

    localparam int NUM_W       = 17;
    localparam int TABLE_SIZE  = 131072;
    localparam int IDX_W       = $clog2(TABLE_SIZE) - 1;
    localparam int ROW_BITS    = 64;
    localparam int BIT_W       = $clog2(ROW_BITS);
    localparam int ROWS        = TABLE_SIZE / 2 / ROW_BITS;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int SQ_W        = NUM_W + 1;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [NUM_W-1:0] LIMIT_RESET  = NUM_W'(100006);
    localparam logic [NUM_W-1:0] TABLE_TOP    = NUM_W'(TABLE_SIZE - 1);
    localparam logic [NUM_W-1:0] FIRST_FACTOR = NUM_W'(3);
    localparam logic [SQ_W-1:0]  FIRST_SQUARE = SQ_W'(9);
    localparam logic [NUM_W-1:0] PRIME_TWO    = NUM_W'(2);
    localparam logic [NUM_W-1:0] NUM_ONE      = NUM_W'(1);

    // Register index, taken from paddr[2].
    localparam logic REG_SIEVE_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F_CHECK,
        ST_F_WAIT,
        ST_MARK,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic             wr_clear;
        logic [ROW_W-1:0] wr_row;
        logic [BIT_W-1:0] wr_bit;
    } map_cmd_t;

    // The bitmap holds odd numbers only: number n lives at index n >> 1.
    function automatic logic [ROW_W-1:0] row_of(input logic [NUM_W-1:0] n);
        logic [IDX_W-1:0] idx;
        idx = n[NUM_W-1:1];
        return idx[IDX_W-1:BIT_W];
    endfunction

    function automatic logic [BIT_W-1:0] bit_of(input logic [NUM_W-1:0] n);
        logic [IDX_W-1:0] idx;
        idx = n[NUM_W-1:1];
        return idx[BIT_W-1:0];
    endfunction

endpackage

// ===== design/pstq_bitmap.sv =====
module pstq_bitmap (
    input  logic                           clk,
    input  pstq_pkg::map_cmd_t             cmd,
    output logic [pstq_pkg::ROW_BITS-1:0]  rd_data
);
    import pstq_pkg::*;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            if (cmd.wr_clear)
            begin
                mem[cmd.wr_row] <= '0;
            end
            else
            begin
                mem[cmd.wr_row][cmd.wr_bit] <= 1'b1;
            end
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/prime_sieve_table_query.sv =====
// Query, once the table is built: the accepting edge starts a registered read of the bitmap; the
// result is registered in ST_LOOKUP once the output is free, and the input stalls meanwhile.
// Table build, on the first item after reset or a limit write: each odd factor up to sqrt(limit)
// is read; a composite one is skipped, a prime one marks its odd multiples from its square.
// Reset clears control state and starts a clearing pass over all 1024 bitmap rows; a write
// to sieve_limit starts the same pass. No item is accepted during it.
module prime_sieve_table_query (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pstq_pkg::NUM_W-1:0]      query_number,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            is_prime,
    output logic                            out_of_range,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pstq_pkg::PADDR_W-1:0]    paddr,
    input  logic [pstq_pkg::PDATA_W-1:0]    pwdata,
    output logic [pstq_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import pstq_pkg::*;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    clr_row_reg, clr_row_next;
    logic                built_reg, built_next;
    logic [NUM_W-1:0]    limit_reg, limit_next;
    logic [NUM_W-1:0]    f_reg, f_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [SQ_W-1:0]     m_reg, m_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                out_valid_reg, out_valid_next;
    logic                is_prime_reg, is_prime_next;
    logic                oor_reg, oor_next;

    map_cmd_t            cmd;
    logic [ROW_BITS-1:0] rd_data;
    logic [NUM_W-1:0]    eff_limit;
    logic [SQ_W-1:0]     sq_adv;
    logic [SQ_W-1:0]     m_adv;
    logic                cfg_write;
    logic                rd_bit;

    pstq_bitmap u_bitmap (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    assign eff_limit = (limit_reg > TABLE_TOP) ? TABLE_TOP : limit_reg;
    // (f + 2)^2 = f^2 + 4f + 4
    assign sq_adv = SQ_W'({1'b0, sq_reg} + {f_reg, 2'b00} + (SQ_W + 1)'(4));
    assign m_adv  = m_reg + {f_reg, 1'b0};
    assign rd_bit = rd_data[bit_reg];

    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SIEVE_LIMIT);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SIEVE_LIMIT) ? PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            built_reg     <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            f_reg         <= '0;
            sq_reg        <= '0;
            m_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            built_reg     <= built_next;
            limit_reg     <= limit_next;
            f_reg         <= f_next;
            sq_reg        <= sq_next;
            m_reg         <= m_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        bit_reg      <= bit_next;
        is_prime_reg <= is_prime_next;
        oor_reg      <= oor_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        built_next     = built_reg;
        limit_next     = limit_reg;
        f_next         = f_reg;
        sq_next        = sq_reg;
        m_next         = m_reg;
        num_next       = num_reg;
        bit_next       = bit_reg;
        is_prime_next  = is_prime_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd            = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_clear = 1'b1;
                cmd.wr_row   = clr_row_reg;
                clr_row_next = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (built_reg)
                begin
                    in_stall = 1'b0;
                    if (in_valid)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_row = row_of(query_number);
                        num_next   = query_number;
                        bit_next   = bit_of(query_number);
                        state_next = ST_LOOKUP;
                    end
                end
                else if (in_valid)
                begin
                    f_next     = FIRST_FACTOR;
                    sq_next    = FIRST_SQUARE;
                    state_next = ST_F_CHECK;
                end
            end
            ST_F_CHECK:
            begin
                if (sq_reg > {1'b0, eff_limit})
                begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_row = row_of(f_reg);
                    bit_next   = bit_of(f_reg);
                    state_next = ST_F_WAIT;
                end
            end
            ST_F_WAIT:
            begin
                if (rd_bit)
                begin
                    // Factor is itself composite: its multiples are already marked.
                    f_next     = f_reg + NUM_W'(2);
                    sq_next    = sq_adv;
                    state_next = ST_F_CHECK;
                end
                else
                begin
                    m_next     = sq_reg;
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (m_reg > {1'b0, eff_limit})
                begin
                    f_next     = f_reg + NUM_W'(2);
                    sq_next    = sq_adv;
                    state_next = ST_F_CHECK;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_row = row_of(m_reg[NUM_W-1:0]);
                    cmd.wr_bit = bit_of(m_reg[NUM_W-1:0]);
                    m_next     = m_adv;
                end
            end
            ST_LOOKUP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    oor_next       = num_reg > eff_limit;
                    if (num_reg > eff_limit)
                    begin
                        is_prime_next = 1'b0;
                    end
                    else if (num_reg == PRIME_TWO)
                    begin
                        is_prime_next = 1'b1;
                    end
                    else if (num_reg == NUM_ONE || !num_reg[0])
                    begin
                        is_prime_next = 1'b0;
                    end
                    else
                    begin
                        is_prime_next = !rd_bit;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // A new limit invalidates the table; clear it and rebuild on the next item.
        if (cfg_write)
        begin
            limit_next   = pwdata[NUM_W-1:0];
            built_next   = 1'b0;
            clr_row_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_prime     = is_prime_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== design/pstq_checker.sv =====
module pstq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            is_prime,
    input logic                            out_of_range,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [pstq_pkg::PADDR_W-1:0]    paddr
);
    import pstq_pkg::*;

    // A result waiting on the output holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_prime) && $stable(out_of_range))
        else $error("stalled result changed");

    // A number above the limit is never reported prime.
    a_oor_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> !is_prime)
        else $error("out of range item reported prime");

    // One item at a time: after an item is taken the input stalls.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while first is in flight");

    // A limit write starts a clearing pass, so no item can be taken next cycle.
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == REG_SIEVE_LIMIT) |=> in_stall)
        else $error("item accepted right after limit write");

endmodule

bind prime_sieve_table_query pstq_checker u_pstq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_prime     (is_prime),
    .out_of_range (out_of_range),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr)
);
